// ===== rtl/fpcc_pkg.sv =====
// Package for the frame protocol classifier and counter.
// Transaction types, protocol constants and byte offsets; no dependencies.
package fpcc_pkg;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [15:0] wire_length;
    } frame_item_t;

    typedef struct packed {
        logic [1:0]  proto_class;
        logic [31:0] source_address;
        logic [31:0] target_address;
        logic [15:0] source_port;
        logic [15:0] target_port;
        logic [31:0] total_frames;
        logic [31:0] tcp_frames;
        logic [31:0] udp_frames;
        logic [47:0] tcp_byte_total;
        logic [47:0] udp_byte_total;
    } result_item_t;

    typedef struct packed {
        logic [1:0]  proto_class;
        logic [31:0] source_address;
        logic [31:0] target_address;
        logic [15:0] source_port;
        logic [15:0] target_port;
    } frame_info_t;

    typedef struct packed {
        logic [31:0] total_frames;
        logic [31:0] tcp_frames;
        logic [31:0] udp_frames;
        logic [47:0] tcp_byte_total;
        logic [47:0] udp_byte_total;
    } frame_stats_t;

    localparam logic [1:0] CLASS_OTHER = 2'd0;
    localparam logic [1:0] CLASS_TCP   = 2'd1;
    localparam logic [1:0] CLASS_UDP   = 2'd2;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

    localparam logic [6:0] OFF_ETYPE_HI  = 7'd12;
    localparam logic [6:0] OFF_ETYPE_LO  = 7'd13;
    localparam logic [6:0] OFF_V6_NEXT   = 7'd20;
    localparam logic [6:0] OFF_V4_PROTO  = 7'd23;
    localparam logic [6:0] OFF_SRC_FIRST = 7'd26;
    localparam logic [6:0] OFF_SRC_LAST  = 7'd29;
    localparam logic [6:0] OFF_DST_FIRST = 7'd30;
    localparam logic [6:0] OFF_DST_LAST  = 7'd33;
    localparam logic [6:0] OFF_V4P_FIRST = 7'd34;
    localparam logic [6:0] OFF_V4P_LAST  = 7'd37;
    localparam logic [6:0] OFF_V6P_FIRST = 7'd54;
    localparam logic [6:0] OFF_V6P_LAST  = 7'd57;
    localparam logic [6:0] OFF_MAX       = 7'd127;

endpackage

// ===== rtl/fpcc_capture.sv =====
// Header capture and classification for one frame.
// Depends on fpcc_pkg; info output reflects the current byte included.
module fpcc_capture (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  fpcc_pkg::frame_item_t item,
    output fpcc_pkg::frame_info_t info
);
    import fpcc_pkg::*;

    logic [6:0]  offset_reg,   offset_next;
    logic [15:0] ether_reg,    ether_next;
    logic [7:0]  v4_proto_reg, v4_proto_next;
    logic [7:0]  v6_next_reg,  v6_next_next;
    logic [31:0] src_reg,      src_next;
    logic [31:0] dst_reg,      dst_next;
    logic [31:0] v4_ports_reg, v4_ports_next;
    logic [31:0] v6_ports_reg, v6_ports_next;
    logic [7:0]  proto;
    logic        is_v4;
    logic        is_v6;
    logic [1:0]  cls;
    logic [7:0]  b;
    logic [6:0]  off;

    always_comb
    begin
        b             = item.frame_byte;
        off           = offset_reg;
        ether_next    = ether_reg;
        v4_proto_next = v4_proto_reg;
        v6_next_next  = v6_next_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        v4_ports_next = v4_ports_reg;
        v6_ports_next = v6_ports_reg;
        if (off == OFF_ETYPE_HI || off == OFF_ETYPE_LO)
            ether_next = {ether_reg[7:0], b};
        else if (off == OFF_V6_NEXT)
            v6_next_next = b;
        else if (off == OFF_V4_PROTO)
            v4_proto_next = b;
        else if (off inside {[OFF_SRC_FIRST:OFF_SRC_LAST]})
            src_next = {src_reg[23:0], b};
        else if (off inside {[OFF_DST_FIRST:OFF_DST_LAST]})
            dst_next = {dst_reg[23:0], b};
        else if (off inside {[OFF_V4P_FIRST:OFF_V4P_LAST]})
            v4_ports_next = {v4_ports_reg[23:0], b};
        else if (off inside {[OFF_V6P_FIRST:OFF_V6P_LAST]})
            v6_ports_next = {v6_ports_reg[23:0], b};

        offset_next = (off < OFF_MAX) ? off + 7'd1 : off;

        is_v4 = (ether_next == ETHERTYPE_IPV4);
        is_v6 = (ether_next == ETHERTYPE_IPV6);
        proto = is_v4 ? v4_proto_next : (is_v6 ? v6_next_next : 8'd0);
        cls   = CLASS_OTHER;
        if (is_v4 || is_v6)
        begin
            if (proto == IP_PROTO_TCP)
                cls = CLASS_TCP;
            else if (proto == IP_PROTO_UDP)
                cls = CLASS_UDP;
        end

        info.proto_class    = cls;
        info.source_address = 32'd0;
        info.target_address = 32'd0;
        info.source_port    = 16'd0;
        info.target_port    = 16'd0;
        if (cls != CLASS_OTHER)
        begin
            if (is_v4)
            begin
                info.source_address = src_next;
                info.target_address = dst_next;
                info.source_port    = v4_ports_next[31:16];
                info.target_port    = v4_ports_next[15:0];
            end
            else
            begin
                info.source_port = v6_ports_next[31:16];
                info.target_port = v6_ports_next[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            ether_reg    <= '0;
            v4_proto_reg <= '0;
            v6_next_reg  <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            v4_ports_reg <= '0;
            v6_ports_reg <= '0;
        end
        else if (accept)
        begin
            if (item.frame_end)
            begin
                offset_reg   <= '0;
                ether_reg    <= '0;
                v4_proto_reg <= '0;
                v6_next_reg  <= '0;
                src_reg      <= '0;
                dst_reg      <= '0;
                v4_ports_reg <= '0;
                v6_ports_reg <= '0;
            end
            else
            begin
                offset_reg   <= offset_next;
                ether_reg    <= ether_next;
                v4_proto_reg <= v4_proto_next;
                v6_next_reg  <= v6_next_next;
                src_reg      <= src_next;
                dst_reg      <= dst_next;
                v4_ports_reg <= v4_ports_next;
                v6_ports_reg <= v6_ports_next;
            end
        end
    end

endmodule

// ===== rtl/fpcc_stats.sv =====
// Saturating frame and byte counters.
// Depends on fpcc_pkg; stats output gives the totals including the ending frame.
module fpcc_stats #(
    parameter int FRAME_COUNT_BITS = 32,
    parameter int BYTE_TOTAL_BITS  = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_done,
    input  logic [1:0]            proto_class,
    input  logic [15:0]           wire_length,
    output fpcc_pkg::frame_stats_t stats
);
    import fpcc_pkg::*;

    logic [FRAME_COUNT_BITS-1:0] frames_reg, frames_next;
    logic [FRAME_COUNT_BITS-1:0] tcp_cnt_reg, tcp_cnt_next;
    logic [FRAME_COUNT_BITS-1:0] udp_cnt_reg, udp_cnt_next;
    logic [BYTE_TOTAL_BITS-1:0]  tcp_sum_reg, tcp_sum_next;
    logic [BYTE_TOTAL_BITS-1:0]  udp_sum_reg, udp_sum_next;
    logic [BYTE_TOTAL_BITS:0]    byte_sum;
    logic [BYTE_TOTAL_BITS-1:0]  sat_total;
    logic [BYTE_TOTAL_BITS-1:0]  acc_sel;
    logic [63:0] frames_ext, tcp_cnt_ext, udp_cnt_ext, tcp_sum_ext, udp_sum_ext;

    always_comb
    begin
        frames_next  = frames_reg;
        tcp_cnt_next = tcp_cnt_reg;
        udp_cnt_next = udp_cnt_reg;
        tcp_sum_next = tcp_sum_reg;
        udp_sum_next = udp_sum_reg;

        acc_sel   = (proto_class == CLASS_UDP) ? udp_sum_reg : tcp_sum_reg;
        byte_sum  = {1'b0, acc_sel} + (BYTE_TOTAL_BITS+1)'(wire_length);
        sat_total = byte_sum[BYTE_TOTAL_BITS] ? '1 : byte_sum[BYTE_TOTAL_BITS-1:0];

        if (frame_done)
        begin
            if (!(&frames_reg))
                frames_next = frames_reg + FRAME_COUNT_BITS'(1);
            if (proto_class == CLASS_TCP)
            begin
                if (!(&tcp_cnt_reg))
                    tcp_cnt_next = tcp_cnt_reg + FRAME_COUNT_BITS'(1);
                tcp_sum_next = sat_total;
            end
            else if (proto_class == CLASS_UDP)
            begin
                if (!(&udp_cnt_reg))
                    udp_cnt_next = udp_cnt_reg + FRAME_COUNT_BITS'(1);
                udp_sum_next = sat_total;
            end
        end

        frames_ext  = 64'(frames_next);
        tcp_cnt_ext = 64'(tcp_cnt_next);
        udp_cnt_ext = 64'(udp_cnt_next);
        tcp_sum_ext = 64'(tcp_sum_next);
        udp_sum_ext = 64'(udp_sum_next);

        stats.total_frames   = frames_ext[31:0];
        stats.tcp_frames     = tcp_cnt_ext[31:0];
        stats.udp_frames     = udp_cnt_ext[31:0];
        stats.tcp_byte_total = tcp_sum_ext[47:0];
        stats.udp_byte_total = udp_sum_ext[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg  <= '0;
            tcp_cnt_reg <= '0;
            udp_cnt_reg <= '0;
            tcp_sum_reg <= '0;
            udp_sum_reg <= '0;
        end
        else
        begin
            frames_reg  <= frames_next;
            tcp_cnt_reg <= tcp_cnt_next;
            udp_cnt_reg <= udp_cnt_next;
            tcp_sum_reg <= tcp_sum_next;
            udp_sum_reg <= udp_sum_next;
        end
    end

endmodule

// ===== rtl/frame_protocol_classify_count.sv =====
// Frame protocol classifier and counter, top level.
// Depends on fpcc_pkg, fpcc_capture and fpcc_stats.
// Takes one frame byte per cycle unless stalled. A frame's result (class,
// IPv4 addresses, ports and running totals) is registered in the cycle
// after the byte marked last is taken; every other byte produces no result.
// The result register is the only stage, so frame_ready drops only while a
// result waits and result_ready is low. Counters saturate; frame counts are
// FRAME_COUNT_BITS wide and byte totals BYTE_TOTAL_BITS wide internally.
module frame_protocol_classify_count #(
    parameter int FRAME_COUNT_BITS = 32,
    parameter int BYTE_TOTAL_BITS  = 48
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_ready,
    input  fpcc_pkg::frame_item_t  frame,
    output logic                   result_valid,
    input  logic                   result_ready,
    output fpcc_pkg::result_item_t result
);
    import fpcc_pkg::*;

    logic         accept;
    logic         frame_done;
    logic         valid_reg;
    result_item_t result_reg;
    frame_info_t  info;
    frame_stats_t stats;

    assign frame_ready  = !valid_reg || result_ready;
    assign accept       = frame_valid && frame_ready;
    assign frame_done   = accept && frame.frame_end;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    fpcc_capture u_capture (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (frame),
        .info   (info)
    );

    fpcc_stats #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS),
        .BYTE_TOTAL_BITS  (BYTE_TOTAL_BITS)
    ) u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_done  (frame_done),
        .proto_class (info.proto_class),
        .wire_length (frame.wire_length),
        .stats       (stats)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (frame_done)
            valid_reg <= 1'b1;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            result_reg.proto_class    <= info.proto_class;
            result_reg.source_address <= info.source_address;
            result_reg.target_address <= info.target_address;
            result_reg.source_port    <= info.source_port;
            result_reg.target_port    <= info.target_port;
            result_reg.total_frames   <= stats.total_frames;
            result_reg.tcp_frames     <= stats.tcp_frames;
            result_reg.udp_frames     <= stats.udp_frames;
            result_reg.tcp_byte_total <= stats.tcp_byte_total;
            result_reg.udp_byte_total <= stats.udp_byte_total;
        end
    end

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> result_valid)
        else $error("frame end did not produce a result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_other_no_ports: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.proto_class == CLASS_OTHER |->
            result.source_port == 16'd0 && result.target_port == 16'd0 &&
            result.source_address == 32'd0)
        else $error("unclassified frame carries header fields");

    a_tcp_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.tcp_frames <= result.total_frames &&
            result.udp_frames <= result.total_frames)
        else $error("per-protocol count exceeds frame count");

endmodule

// ===== dv/frame_protocol_classify_count_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for frame_protocol_classify_count: streams frames byte by byte,
// predicts class, addresses, ports and saturating totals, checks every result transaction.
// Depends on fpcc_pkg and the frame_protocol_classify_count RTL.
module frame_protocol_classify_count_tb;
    import fpcc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         frame_valid = 1'b0;
    logic         frame_ready;
    frame_item_t  frame = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    result_item_t result;

    frame_item_t  byte_queue[$];
    result_item_t predicted_results[$];
    int           bytes_total = 0;
    int           bytes_taken = 0;
    int           frames_queued = 0;
    int           errors = 0;
    int           cycles = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    // per-frame capture and running totals
    logic [6:0]  cur_offset = '0;
    logic [15:0] cur_etype = '0;
    logic [7:0]  cur_v4_proto = '0;
    logic [7:0]  cur_v6_next = '0;
    logic [31:0] cur_src = '0;
    logic [31:0] cur_dst = '0;
    logic [31:0] cur_v4_ports = '0;
    logic [31:0] cur_v6_ports = '0;
    logic [31:0] frame_cnt = '0;
    logic [31:0] tcp_cnt = '0;
    logic [31:0] udp_cnt = '0;
    logic [47:0] tcp_octet_sum = '0;
    logic [47:0] udp_octet_sum = '0;

    frame_protocol_classify_count DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] count_sat(logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic logic [47:0] add_sat(logic [47:0] acc, logic [15:0] len);
        logic [48:0] sum;
        sum = {1'b0, acc} + {33'd0, len};
        return sum[48] ? '1 : sum[47:0];
    endfunction

    function automatic int send_idle_pct();
        int phase;
        phase = (bytes_total == 0) ? 0 : (bytes_taken * 3) / bytes_total;
        return (phase == 0) ? 15 : (phase == 1) ? 77 : 0;
    endfunction

    function automatic int recv_idle_pct();
        int phase;
        phase = (bytes_total == 0) ? 0 : (bytes_taken * 3) / bytes_total;
        return (phase == 0) ? 77 : (phase == 1) ? 15 : 0;
    endfunction

    task automatic classify_byte(input frame_item_t it);
        logic [7:0]   proto;
        logic [1:0]   cls;
        logic [31:0]  ports;
        result_item_t r;
        proto = '0;
        cls = CLASS_OTHER;
        if (cur_offset == OFF_ETYPE_HI || cur_offset == OFF_ETYPE_LO)
            cur_etype = {cur_etype[7:0], it.frame_byte};
        else if (cur_offset == OFF_V6_NEXT)
            cur_v6_next = it.frame_byte;
        else if (cur_offset == OFF_V4_PROTO)
            cur_v4_proto = it.frame_byte;
        else if (cur_offset >= OFF_SRC_FIRST && cur_offset <= OFF_SRC_LAST)
            cur_src = {cur_src[23:0], it.frame_byte};
        else if (cur_offset >= OFF_DST_FIRST && cur_offset <= OFF_DST_LAST)
            cur_dst = {cur_dst[23:0], it.frame_byte};
        else if (cur_offset >= OFF_V4P_FIRST && cur_offset <= OFF_V4P_LAST)
            cur_v4_ports = {cur_v4_ports[23:0], it.frame_byte};
        else if (cur_offset >= OFF_V6P_FIRST && cur_offset <= OFF_V6P_LAST)
            cur_v6_ports = {cur_v6_ports[23:0], it.frame_byte};
        if (cur_offset != OFF_MAX)
            cur_offset = cur_offset + 7'd1;
        if (it.frame_end)
        begin
            if (cur_etype == ETHERTYPE_IPV4)
                proto = cur_v4_proto;
            else if (cur_etype == ETHERTYPE_IPV6)
                proto = cur_v6_next;
            if (cur_etype == ETHERTYPE_IPV4 || cur_etype == ETHERTYPE_IPV6)
            begin
                if (proto == IP_PROTO_TCP)
                    cls = CLASS_TCP;
                else if (proto == IP_PROTO_UDP)
                    cls = CLASS_UDP;
            end
            frame_cnt = count_sat(frame_cnt);
            if (cls == CLASS_TCP)
            begin
                tcp_cnt = count_sat(tcp_cnt);
                tcp_octet_sum = add_sat(tcp_octet_sum, it.wire_length);
            end
            else if (cls == CLASS_UDP)
            begin
                udp_cnt = count_sat(udp_cnt);
                udp_octet_sum = add_sat(udp_octet_sum, it.wire_length);
            end
            r = '0;
            r.proto_class = cls;
            if (cls != CLASS_OTHER)
            begin
                ports = cur_v6_ports;
                if (cur_etype == ETHERTYPE_IPV4)
                begin
                    r.source_address = cur_src;
                    r.target_address = cur_dst;
                    ports = cur_v4_ports;
                end
                r.source_port = ports[31:16];
                r.target_port = ports[15:0];
            end
            r.total_frames = frame_cnt;
            r.tcp_frames = tcp_cnt;
            r.udp_frames = udp_cnt;
            r.tcp_byte_total = tcp_octet_sum;
            r.udp_byte_total = udp_octet_sum;
            predicted_results.push_back(r);
            cur_offset = '0;
            cur_etype = '0;
            cur_v4_proto = '0;
            cur_v6_next = '0;
            cur_src = '0;
            cur_dst = '0;
            cur_v4_ports = '0;
            cur_v6_ports = '0;
        end
    endtask

    task automatic queue_frame(input int len, input logic [15:0] etype, input logic [7:0] v4p,
                               input logic [7:0] v6n, input logic [15:0] wlen, input bit ones);
        logic [7:0]  bytes[$];
        frame_item_t it;
        for (int i = 0; i < len; i++)
            bytes.push_back(ones ? 8'hFF : 8'($urandom));
        if (len > OFF_ETYPE_LO)
        begin
            bytes[OFF_ETYPE_HI] = etype[15:8];
            bytes[OFF_ETYPE_LO] = etype[7:0];
        end
        if (len > OFF_V6_NEXT)
            bytes[OFF_V6_NEXT] = v6n;
        if (len > OFF_V4_PROTO)
            bytes[OFF_V4_PROTO] = v4p;
        for (int i = 0; i < len; i++)
        begin
            it.frame_byte = bytes[i];
            it.frame_end = (i == len - 1);
            it.wire_length = (i == len - 1) ? wlen : 16'($urandom);
            byte_queue.push_back(it);
        end
        frames_queued++;
    endtask

    task automatic queue_random_frame();
        int          len;
        int          pick;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [7:0]  noise;
        pick = $urandom_range(99);
        if (pick < 30)
            len = $urandom_range(30, 1);
        else if (pick < 85)
            len = $urandom_range(60, 34);
        else if (pick < 95)
            len = $urandom_range(80, 61);
        else
            len = $urandom_range(150, 128);
        pick = $urandom_range(99);
        if (pick < 40)
            etype = ETHERTYPE_IPV4;
        else if (pick < 75)
            etype = ETHERTYPE_IPV6;
        else if (pick < 85)
            etype = {8'h08, 8'($urandom)};
        else
            etype = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)
            proto = IP_PROTO_TCP;
        else if (pick < 80)
            proto = IP_PROTO_UDP;
        else
            proto = 8'($urandom);
        noise = ($urandom_range(1) == 0) ? 8'($urandom)
              : (($urandom_range(1) == 0) ? IP_PROTO_TCP : IP_PROTO_UDP);
        if (etype == ETHERTYPE_IPV6)
            queue_frame(len, etype, noise, proto, 16'($urandom), 1'b0);
        else
            queue_frame(len, etype, proto, noise, 16'($urandom), 1'b0);
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        bit took;
        took = 1'b0;
        if (rst_n)
        begin
            if (frame_valid && frame_ready)
            begin
                classify_byte(frame);
                bytes_taken++;
                took = 1'b1;
            end
            if (!frame_valid || took)
            begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct())
                begin
                    frame <= byte_queue.pop_front();
                    frame_valid <= 1'b1;
                end
                else
                    frame_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with one long hold-off late in the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else if (!hold_done && bytes_total > 0 && bytes_taken >= (bytes_total * 3) / 4)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result transaction: class %0d", result.proto_class);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("proto_class", 48'(want.proto_class),
                            48'(result.proto_class));
                check_field("source_address", 48'(want.source_address),
                            48'(result.source_address));
                check_field("target_address", 48'(want.target_address),
                            48'(result.target_address));
                check_field("source_port", 48'(want.source_port),
                            48'(result.source_port));
                check_field("target_port", 48'(want.target_port),
                            48'(result.target_port));
                check_field("total_frames", 48'(want.total_frames),
                            48'(result.total_frames));
                check_field("tcp_frames", 48'(want.tcp_frames),
                            48'(result.tcp_frames));
                check_field("udp_frames", 48'(want.udp_frames),
                            48'(result.udp_frames));
                check_field("tcp_byte_total", want.tcp_byte_total, result.tcp_byte_total);
                check_field("udp_byte_total", want.udp_byte_total, result.udp_byte_total);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        // directed: one-byte frames, field extremes, short, partial and long frames
        queue_frame(1, 16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0);
        queue_frame(1, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        queue_frame(38, ETHERTYPE_IPV4, IP_PROTO_TCP, 8'hFF, 16'hFFFF, 1'b1);
        queue_frame(58, ETHERTYPE_IPV6, 8'hFF, IP_PROTO_UDP, 16'h0001, 1'b1);
        queue_frame(24, ETHERTYPE_IPV4, IP_PROTO_UDP, 8'h00, 16'h8000, 1'b0);
        queue_frame(56, ETHERTYPE_IPV6, IP_PROTO_UDP, IP_PROTO_TCP, 16'h0040, 1'b0);
        queue_frame(40, ETHERTYPE_IPV6, IP_PROTO_TCP, 8'h3B, 16'h0100, 1'b0);
        queue_frame(40, ETHERTYPE_IPV4, 8'd1, IP_PROTO_TCP, 16'h0200, 1'b0);
        queue_frame(40, 16'h0806, IP_PROTO_TCP, IP_PROTO_UDP, 16'h0300, 1'b0);
        queue_frame(13, 16'h0800, IP_PROTO_TCP, 8'h00, 16'h0400, 1'b0);
        queue_frame(140, ETHERTYPE_IPV4, IP_PROTO_UDP, 8'h00, 16'hFFFE, 1'b0);
        queue_frame(60, ETHERTYPE_IPV4, IP_PROTO_TCP, 8'h00, 16'h05DC, 1'b0);
        while (byte_queue.size() < 1200 || frames_queued < 20)
            queue_random_frame();
        bytes_total = byte_queue.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < bytes_total || predicted_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
